@@ rtl/core/detd_pkg.sv @@
// Shared types, register codes and reset values of the DALI edge timing decoder.
`default_nettype none

package detd_pkg;

	localparam int WORD_BITS_DEFAULT = 24;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_ACTION     = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BACKWARD_ACTION    = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MANGLED_ACTION     = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_BIT_TIME      = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BIT_TOLERANCE      = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_DURATION   = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_BACKWARD_DURATION  = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_DURATION_TOLERANCE = 4'd7;

	// register reset values
	localparam logic [1:0]  RST_FORWARD_ACTION     = 2'd3;
	localparam logic [1:0]  RST_BACKWARD_ACTION    = 2'd3;
	localparam logic [1:0]  RST_MANGLED_ACTION     = 2'd1;
	localparam logic [15:0] RST_HALF_BIT_TIME      = 16'd417;
	localparam logic [15:0] RST_BIT_TOLERANCE      = 16'd150;
	localparam logic [15:0] RST_FORWARD_DURATION   = 16'd15411;
	localparam logic [15:0] RST_BACKWARD_DURATION  = 16'd8700;
	localparam logic [15:0] RST_DURATION_TOLERANCE = 16'd1500;

	// edge kinds
	localparam logic [1:0] EDGE_NONE   = 2'd0;
	localparam logic [1:0] EDGE_RISING = 2'd1;

	// frame kinds
	localparam logic [1:0] FRAME_FORWARD  = 2'd0;
	localparam logic [1:0] FRAME_BACKWARD = 2'd1;
	localparam logic [1:0] FRAME_MANGLED  = 2'd2;

	// gaps below this are line glitches
	localparam logic [15:0] GLITCH_US = 16'd40;

	typedef struct packed {
		logic [1:0]  forward_action;
		logic [1:0]  backward_action;
		logic [1:0]  mangled_action;
		logic [15:0] half_bit_time;
		logic [15:0] bit_tolerance;
		logic [15:0] forward_duration;
		logic [15:0] backward_duration;
		logic [15:0] duration_tolerance;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  edge_kind;
		logic [15:0] edge_time;
		logic        frame_end;
	} edge_word_t;

	typedef struct packed {
		logic [1:0] frame_kind;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
	} frame_word_t;

	// classified edge, as queued between front and back
	typedef struct packed {
		logic [1:0]  edge_kind;
		logic [15:0] edge_time;
		logic        frame_end;
		logic        start_ok;
		logic [1:0]  frame_type;
	} entry_t;

endpackage

`default_nettype wire

@@ rtl/core/detd_front.sv @@
// Front part: classifies each edge word against start and frame duration windows.
`default_nettype none

module detd_front (
	input  wire detd_pkg::cfg_t       cfg,
	input  wire detd_pkg::edge_word_t edge_word,
	output detd_pkg::entry_t          entry
);

	logic [16:0] time_plus_bt;
	logic [16:0] half_plus_bt;
	logic        start_win;
	logic [16:0] time_plus_dt;
	logic [16:0] fwd_plus_dt;
	logic [16:0] bwd_plus_dt;
	logic        fwd_win;
	logic        bwd_win;

	always_comb begin
		// v > n - t and v < n + t, kept unsigned as v + t > n
		time_plus_bt = {1'b0, edge_word.edge_time} + {1'b0, cfg.bit_tolerance};
		half_plus_bt = {1'b0, cfg.half_bit_time} + {1'b0, cfg.bit_tolerance};
		start_win    = (time_plus_bt > {1'b0, cfg.half_bit_time}) &&
			({1'b0, edge_word.edge_time} < half_plus_bt);

		time_plus_dt = {1'b0, edge_word.edge_time} + {1'b0, cfg.duration_tolerance};
		fwd_plus_dt  = {1'b0, cfg.forward_duration} + {1'b0, cfg.duration_tolerance};
		bwd_plus_dt  = {1'b0, cfg.backward_duration} + {1'b0, cfg.duration_tolerance};
		fwd_win = (time_plus_dt > {1'b0, cfg.forward_duration}) &&
			({1'b0, edge_word.edge_time} < fwd_plus_dt);
		bwd_win = (time_plus_dt > {1'b0, cfg.backward_duration}) &&
			({1'b0, edge_word.edge_time} < bwd_plus_dt);

		entry.edge_kind = edge_word.edge_kind;
		entry.edge_time = edge_word.edge_time;
		entry.frame_end = edge_word.frame_end;
		entry.start_ok  = (edge_word.edge_kind == detd_pkg::EDGE_RISING) && start_win;
		if (fwd_win) begin
			entry.frame_type = detd_pkg::FRAME_FORWARD;
		end else if (bwd_win) begin
			entry.frame_type = detd_pkg::FRAME_BACKWARD;
		end else begin
			entry.frame_type = detd_pkg::FRAME_MANGLED;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/detd_queue.sv @@
// Two-word queue between the classifying front and the decoding back.
`default_nettype none

module detd_queue (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push_valid,
	output logic                    push_ready,
	input  wire detd_pkg::entry_t   push_entry,
	output logic                    pop_valid,
	input  wire                     pop_ready,
	output detd_pkg::entry_t        pop_entry
);

	detd_pkg::entry_t entries_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_entry  = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/detd_back.sv @@
// Back part: Manchester bit decoding, frame close-out and the result register.
`default_nettype none

module detd_back #(
	parameter int WORD_BITS = detd_pkg::WORD_BITS_DEFAULT
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire detd_pkg::cfg_t     cfg,
	input  wire                     entry_valid,
	output logic                    entry_ready,
	input  wire detd_pkg::entry_t   entry,
	output logic                    frame_valid,
	input  wire                     frame_ready,
	output detd_pkg::frame_word_t   frame_word
);

	localparam int PosW = $clog2(WORD_BITS);
	localparam int ExtW = (WORD_BITS > 24) ? WORD_BITS : 24;

	typedef enum logic [3:0] {
		PH_INIT       = 4'b0001,
		PH_CHECKSTART = 4'b0010,
		PH_BITREADY   = 4'b0100,
		PH_END        = 4'b1000
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [WORD_BITS-1:0]   shift_q, shift_n;
	logic [PosW-1:0]        pos_q, pos_n;
	logic                   full_q, full_n;
	logic [15:0]            last_q, last_n;
	logic                   err_q, err_n;

	logic [15:0]            gap;
	logic [16:0]            gap_plus_bt;
	logic [16:0]            half_plus_bt;
	logic [16:0]            two_half;
	logic [17:0]            two_half_plus_bt;
	logic                   half_win;
	logic                   full_win;
	logic [1:0]             action;
	logic                   emit;
	logic [ExtW-1:0]        shift_ext;
	logic                   pop;
	logic                   out_valid_q;
	detd_pkg::frame_word_t  out_word_q;

	assign entry_ready = !out_valid_q || frame_ready;
	assign pop         = entry_valid && entry_ready;
	assign frame_valid = out_valid_q;
	assign frame_word  = out_word_q;

	always_comb begin
		gap              = entry.edge_time - last_q;
		gap_plus_bt      = {1'b0, gap} + {1'b0, cfg.bit_tolerance};
		half_plus_bt     = {1'b0, cfg.half_bit_time} + {1'b0, cfg.bit_tolerance};
		two_half         = {cfg.half_bit_time, 1'b0};
		two_half_plus_bt = {1'b0, two_half} + {2'b00, cfg.bit_tolerance};
		half_win = (gap_plus_bt > {1'b0, cfg.half_bit_time}) && ({1'b0, gap} < half_plus_bt);
		full_win = (gap_plus_bt > two_half) && ({2'b00, gap} < two_half_plus_bt);
	end

	always_comb begin
		phase_n = phase_q;
		shift_n = shift_q;
		pos_n   = pos_q;
		full_n  = full_q;
		last_n  = last_q;
		err_n   = err_q;
		if (!err_q && phase_q != PH_END) begin
			case (phase_q)
				PH_INIT: begin
					phase_n = PH_CHECKSTART;
				end
				PH_CHECKSTART: begin
					if (entry.start_ok) begin
						phase_n = PH_BITREADY;
						last_n  = entry.edge_time;
					end else begin
						err_n = 1'b1;
					end
				end
				PH_BITREADY: begin
					if (entry.edge_kind == detd_pkg::EDGE_NONE) begin
						phase_n = PH_END;
					end else if (half_win) begin
						// mid-bit transition: hold
					end else if (full_win) begin
						if (!full_q) begin
							if (entry.edge_kind == detd_pkg::EDGE_RISING) begin
								shift_n[pos_q] = 1'b1;
							end
							if (pos_q == '0) begin
								full_n = 1'b1;
							end else begin
								pos_n = pos_q - 1'b1;
							end
						end
						last_n = entry.edge_time;
					end else if (gap < detd_pkg::GLITCH_US) begin
						// glitch: drop
					end else begin
						err_n = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (entry.frame_type)
			detd_pkg::FRAME_FORWARD:  action = cfg.forward_action;
			detd_pkg::FRAME_BACKWARD: action = cfg.backward_action;
			default:                  action = 2'd1;
		endcase
		emit      = entry.frame_end && action[0] &&
			(action[1] || (err_n && cfg.mangled_action[1]));
		shift_ext = ExtW'(shift_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_INIT;
			shift_q     <= '0;
			pos_q       <= PosW'(WORD_BITS - 1);
			full_q      <= 1'b0;
			last_q      <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (entry.frame_end) begin
					phase_q <= PH_INIT;
					shift_q <= '0;
					pos_q   <= PosW'(WORD_BITS - 1);
					full_q  <= 1'b0;
					last_q  <= '0;
					err_q   <= 1'b0;
				end else begin
					phase_q <= phase_n;
					shift_q <= shift_n;
					pos_q   <= pos_n;
					full_q  <= full_n;
					last_q  <= last_n;
					err_q   <= err_n;
				end
				out_valid_q <= emit;
			end else if (frame_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_word_q.frame_kind  <= err_n ? detd_pkg::FRAME_MANGLED : entry.frame_type;
			out_word_q.first_byte  <= shift_ext[23:16];
			out_word_q.second_byte <= shift_ext[15:8];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/dali_edge_timing_decoder_unit.sv @@
// Top level of the DALI edge timing decoder: configuration registers, front, queue, back.
`default_nettype none

// Usage
//  edge channel (edge_valid/edge_ready/edge_word): one timestamped line edge per word,
//   edge_time in microseconds since frame start, frame_end set on the last edge.
//  frame channel (frame_valid/frame_ready/frame_word): at most one word per frame,
//   frame kind plus the two decoded bytes, sent when the frame's action bits allow.
//  configuration: cfg_we writes cfg_data into register cfg_index at the clock edge;
//   write only while the block is idle.
// Result path: a result word passes through the queue and is registered in the result
//  register once its frame_end edge is decoded; earlier queued edges or a stalled
//  frame channel hold it back.
// Throughput: one edge word per cycle while no stalled result holds the back, set by
//  the single decode step of the back part (gap subtract, window compare, shift-in).
// Stalls: a two-word queue parts front and back, and the result register lets the back
//  keep decoding edges that produce no word while no result is waiting. While
//  frame_ready is low with a word pending, the back holds, the queue fills and
//  edge_ready drops once it is full.
// Reset: arst_n clears the decoder to the start of a frame, empties the queue and the
//  result register, and loads every configuration register with its default.
module dali_edge_timing_decoder_unit #(
	parameter int WORD_BITS = detd_pkg::WORD_BITS_DEFAULT
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   edge_valid,
	output logic                                  edge_ready,
	input  wire detd_pkg::edge_word_t             edge_word,
	output logic                                  frame_valid,
	input  wire                                   frame_ready,
	output detd_pkg::frame_word_t                 frame_word,
	input  wire                                   cfg_we,
	input  wire [detd_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire [detd_pkg::CFG_DATA_W-1:0]        cfg_data
);

	detd_pkg::cfg_t   cfg_q;
	detd_pkg::entry_t front_entry;
	detd_pkg::entry_t queue_entry;
	logic             queue_valid;
	logic             back_ready;

	// configuration registers; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.forward_action     <= detd_pkg::RST_FORWARD_ACTION;
			cfg_q.backward_action    <= detd_pkg::RST_BACKWARD_ACTION;
			cfg_q.mangled_action     <= detd_pkg::RST_MANGLED_ACTION;
			cfg_q.half_bit_time      <= detd_pkg::RST_HALF_BIT_TIME;
			cfg_q.bit_tolerance      <= detd_pkg::RST_BIT_TOLERANCE;
			cfg_q.forward_duration   <= detd_pkg::RST_FORWARD_DURATION;
			cfg_q.backward_duration  <= detd_pkg::RST_BACKWARD_DURATION;
			cfg_q.duration_tolerance <= detd_pkg::RST_DURATION_TOLERANCE;
		end else if (cfg_we) begin
			case (cfg_index)
				detd_pkg::REG_FORWARD_ACTION:     cfg_q.forward_action     <= cfg_data[1:0];
				detd_pkg::REG_BACKWARD_ACTION:    cfg_q.backward_action    <= cfg_data[1:0];
				detd_pkg::REG_MANGLED_ACTION:     cfg_q.mangled_action     <= cfg_data[1:0];
				detd_pkg::REG_HALF_BIT_TIME:      cfg_q.half_bit_time      <= cfg_data;
				detd_pkg::REG_BIT_TOLERANCE:      cfg_q.bit_tolerance      <= cfg_data;
				detd_pkg::REG_FORWARD_DURATION:   cfg_q.forward_duration   <= cfg_data;
				detd_pkg::REG_BACKWARD_DURATION:  cfg_q.backward_duration  <= cfg_data;
				detd_pkg::REG_DURATION_TOLERANCE: cfg_q.duration_tolerance <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// classify the edge as it is accepted
	detd_front u_front (
		.cfg       (cfg_q),
		.edge_word (edge_word),
		.entry     (front_entry)
	);

	// decouple acceptance from decoding
	detd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (edge_valid),
		.push_ready (edge_ready),
		.push_entry (front_entry),
		.pop_valid  (queue_valid),
		.pop_ready  (back_ready),
		.pop_entry  (queue_entry)
	);

	// advance the bit decoder and close frames
	detd_back #(
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.entry_valid (queue_valid),
		.entry_ready (back_ready),
		.entry       (queue_entry),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame_word  (frame_word)
	);

endmodule

`default_nettype wire

@@ rtl/core/detd_checker.sv @@
// Port-level checker for the DALI edge timing decoder, bound to the top level.
`default_nettype none

module detd_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        edge_valid,
	input wire                        edge_ready,
	input wire detd_pkg::edge_word_t  edge_word,
	input wire                        frame_valid,
	input wire                        frame_ready,
	input wire detd_pkg::frame_word_t frame_word
);

	// a stalled result word holds
	a_frame_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=> frame_valid && $stable(frame_word))
		else $error("stalled frame word changed or dropped");

	// frame kind is forward, backward or mangled
	a_frame_kind: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> (frame_word.frame_kind == detd_pkg::FRAME_FORWARD ||
			frame_word.frame_kind == detd_pkg::FRAME_BACKWARD ||
			frame_word.frame_kind == detd_pkg::FRAME_MANGLED))
		else $error("illegal frame kind");

	// the edge side only backs up behind a stalled frame channel
	a_edge_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!edge_ready |-> $past(frame_valid && !frame_ready))
		else $error("edge channel stalled without frame back-pressure");

endmodule

bind dali_edge_timing_decoder_unit detd_checker u_checker (.*);

`default_nettype wire

@@ verif/dali_edge_timing_decoder_unit_tb.sv @@
// Self-checking testbench of the DALI edge timing decoder: random frames against a predictor.
`timescale 1ns / 100ps

module dali_edge_timing_decoder_unit_tb;
	import detd_pkg::*;

	// Clock, reset and run bounds
	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 5;
	// result passes the two-word queue and the result register after frame_end: settle well past that
	localparam int SETTLE_CYCLES = 16;
	// no word moves for this long: well above the longest random gap and the
	// between-phase drain plus pause plus up to nine register writes
	localparam int QUIET_LIMIT = 2000;
	localparam int TARGET_EDGES = 500;
	localparam int FRAMES_PER_PHASE = 6;
	localparam int MAX_PHASES = 80;

	// Codes the package leaves out
	localparam logic [1:0] EDGE_FALLING = 2'd2;
	localparam logic [1:0] EDGE_ODD = 2'd3;	// treated as a falling edge
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 4'd15;
	localparam int ACT_DECODE_BIT = 0;
	localparam int ACT_EMIT_BIT = 1;
	localparam logic [1:0] ACTION_DECODE_ONLY = 2'b01;

	typedef enum logic [3:0] {
		DEC_WAIT_FIRST  = 4'b0001,
		DEC_CHECK_START = 4'b0010,
		DEC_BITS        = 4'b0100,
		DEC_DONE        = 4'b1000
	} dec_phase_t;

	typedef enum int {
		PACE_NONE,
		PACE_SENDER,
		PACE_RECEIVER,
		PACE_BOTH
	} pace_t;

	// Predicts the frame words of the decoder and checks them in order
	class frame_scoreboard_t;
		cfg_t regs;
		dec_phase_t phase;
		logic [31:0] shift_word;
		logic [4:0] bit_pos;
		bit word_full;
		logic [15:0] last_bit_us;
		bit bad;
		frame_word_t pending_frames[$];
		int mismatches;
		int frames_checked;
		int frames_predicted;

		function new();
			regs.forward_action = RST_FORWARD_ACTION;
			regs.backward_action = RST_BACKWARD_ACTION;
			regs.mangled_action = RST_MANGLED_ACTION;
			regs.half_bit_time = RST_HALF_BIT_TIME;
			regs.bit_tolerance = RST_BIT_TOLERANCE;
			regs.forward_duration = RST_FORWARD_DURATION;
			regs.backward_duration = RST_BACKWARD_DURATION;
			regs.duration_tolerance = RST_DURATION_TOLERANCE;
			mismatches = 0;
			frames_checked = 0;
			frames_predicted = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			phase = DEC_WAIT_FIRST;
			shift_word = '0;
			bit_pos = 5'(WORD_BITS_DEFAULT - 1);
			word_full = 1'b0;
			last_bit_us = '0;
			bad = 1'b0;
		endfunction

		// strict window around a nominal value
		function bit in_window(int v, int nominal, int tol);
			return (v < nominal + tol) && (v > nominal - tol);
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_FORWARD_ACTION: regs.forward_action = data[1:0];
			REG_BACKWARD_ACTION: regs.backward_action = data[1:0];
			REG_MANGLED_ACTION: regs.mangled_action = data[1:0];
			REG_HALF_BIT_TIME: regs.half_bit_time = data;
			REG_BIT_TOLERANCE: regs.bit_tolerance = data;
			REG_FORWARD_DURATION: regs.forward_duration = data;
			REG_BACKWARD_DURATION: regs.backward_duration = data;
			REG_DURATION_TOLERANCE: regs.duration_tolerance = data;
			default: begin
			end
			endcase
		endfunction

		// Advance the decoder by one accepted edge word; queue the frame word it causes
		function void note_edge(edge_word_t w);
			logic [15:0] gap;
			logic [1:0] kind;
			logic [1:0] action;
			frame_word_t res;
			int h;
			int t;
			h = regs.half_bit_time;
			t = regs.bit_tolerance;
			if (!bad && phase != DEC_DONE) begin
				case (phase)
				DEC_WAIT_FIRST: phase = DEC_CHECK_START;
				DEC_CHECK_START: begin
					if (w.edge_kind == EDGE_RISING && in_window(w.edge_time, h, t)) begin
						phase = DEC_BITS;
						last_bit_us = w.edge_time;
					end else begin
						bad = 1'b1;
					end
				end
				default: begin
					if (w.edge_kind == EDGE_NONE) begin
						phase = DEC_DONE;
					end else begin
						gap = w.edge_time - last_bit_us;
						// half-bit gaps are mid-bit transitions: leave them alone
						if (!in_window(gap, h, t)) begin
							if (in_window(gap, 2 * h, t)) begin
								// drop bits once the word is full
								if (!word_full) begin
									if (w.edge_kind == EDGE_RISING)
										shift_word[bit_pos] = 1'b1;
									if (bit_pos == 0)
										word_full = 1'b1;
									else
										bit_pos = bit_pos - 1'b1;
								end
								last_bit_us = w.edge_time;
							end else if (gap >= GLITCH_US) begin
								bad = 1'b1;
							end
						end
					end
				end
				endcase
			end
			if (w.frame_end) begin
				if (in_window(w.edge_time, regs.forward_duration, regs.duration_tolerance)) begin
					kind = FRAME_FORWARD;
					action = regs.forward_action;
				end else if (in_window(w.edge_time, regs.backward_duration,
						regs.duration_tolerance)) begin
					kind = FRAME_BACKWARD;
					action = regs.backward_action;
				end else begin
					kind = FRAME_MANGLED;
					action = ACTION_DECODE_ONLY;
				end
				if (action[ACT_DECODE_BIT] && (action[ACT_EMIT_BIT] ||
						(bad && regs.mangled_action[ACT_EMIT_BIT]))) begin
					res.frame_kind = bad ? FRAME_MANGLED : kind;
					res.first_byte = shift_word[23:16];
					res.second_byte = shift_word[15:8];
					pending_frames.push_back(res);
					frames_predicted++;
				end
				clear_frame();
			end
		endfunction

		// print one line per mismatch and count it
		task report_mismatch(string msg);
			$display("%0t MISMATCH %s", $time, msg);
			mismatches++;
		endtask

		task check_frame(frame_word_t got);
			frame_word_t want;
			if (pending_frames.size() == 0) begin
				report_mismatch($sformatf("unexpected frame word %h", got));
				return;
			end
			want = pending_frames.pop_front();
			frames_checked++;
			if (got.frame_kind !== want.frame_kind)
				report_mismatch($sformatf("frame_kind %0d, want %0d",
					got.frame_kind, want.frame_kind));
			if (got.first_byte !== want.first_byte)
				report_mismatch($sformatf("first_byte %h, want %h",
					got.first_byte, want.first_byte));
			if (got.second_byte !== want.second_byte)
				report_mismatch($sformatf("second_byte %h, want %h",
					got.second_byte, want.second_byte));
		endtask
	endclass

	// DUT connections, all driven from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic edge_valid = 1'b0;
	logic edge_ready;
	edge_word_t edge_word = '0;
	logic frame_valid;
	logic frame_ready = 1'b0;
	frame_word_t frame_word;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	frame_scoreboard_t sb;
	edge_word_t frame_edges[$];
	pace_t pace_mode = PACE_NONE;
	int edges_sent = 0;
	int frames_sent = 0;
	int settings_used = 0;
	int quiet_cycles = 0;
	int phase_count;

	dali_edge_timing_decoder_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.edge_valid  (edge_valid),
		.edge_ready  (edge_ready),
		.edge_word   (edge_word),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame_word  (frame_word),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Decide whether a side sits out this cycle under the current pacing
	function automatic bit pace_gap(bit sender);
		case (pace_mode)
		PACE_SENDER: return sender && ($urandom_range(99) < 61);
		PACE_RECEIVER: return !sender && ($urandom_range(99) < 61);
		PACE_BOTH: return $urandom_range(99) < 38;
		default: return 1'b0;
		endcase
	endfunction

	// symmetric offset strictly inside a tolerance window
	function automatic int jitter(int tol);
		if (tol <= 1)
			return 0;
		return int'($urandom_range(2 * (tol - 1))) - (tol - 1);
	endfunction

	function automatic logic [1:0] any_transition();
		return 2'($urandom_range(1, 3));
	endfunction

	function automatic logic [1:0] zero_transition();
		return $urandom_range(1) ? EDGE_FALLING : EDGE_ODD;
	endfunction

	function automatic void push_edge(logic [1:0] kind, logic [15:0] at_us, logic fin);
		edge_word_t w;
		w.edge_kind = kind;
		w.edge_time = at_us;
		w.frame_end = fin;
		frame_edges.push_back(w);
	endfunction

	// Pick a frame duration: near forward, near backward, or anywhere
	function automatic logic [15:0] end_time();
		int r;
		int dt;
		r = $urandom_range(99);
		dt = sb.regs.duration_tolerance;
		if (r < 40)
			return 16'(int'(sb.regs.forward_duration) + jitter(dt));
		if (r < 70)
			return 16'(int'(sb.regs.backward_duration) + jitter(dt));
		return 16'($urandom);
	endfunction

	// Build one frame of edges: mostly well-formed Manchester at the current timing,
	// some with one corrupted edge, some pure noise
	function automatic void build_frame();
		int h;
		int t;
		int nbits;
		int pick;
		int idx;
		logic [15:0] at_us;
		edge_word_t w;
		frame_edges.delete();
		h = sb.regs.half_bit_time;
		t = sb.regs.bit_tolerance;
		pick = $urandom_range(99);
		if (pick < 10) begin
			nbits = $urandom_range(1, 8);
			repeat (nbits - 1)
				push_edge(2'($urandom_range(3)), 16'($urandom), 1'b0);
			push_edge(2'($urandom_range(3)), end_time(), 1'b1);
			return;
		end
		// the first edge is skipped by the decoder, content does not matter
		push_edge(2'($urandom_range(3)), 16'($urandom_range(60)), 1'b0);
		at_us = 16'(h + jitter(t));
		push_edge(EDGE_RISING, at_us, 1'b0);
		// keep most frames short, some long enough to overflow the shift word
		nbits = ($urandom_range(99) < 65) ? $urandom_range(8) : $urandom_range(16, 27);
		for (int i = 0; i < nbits; i++) begin
			if ($urandom_range(99) < 10)
				push_edge(any_transition(), at_us + 16'($urandom_range(1, 39)), 1'b0);
			if ($urandom_range(1))
				push_edge(any_transition(), at_us + 16'(h + jitter(t)), 1'b0);
			at_us = at_us + 16'(2 * h + jitter(t));
			push_edge($urandom_range(1) ? EDGE_RISING : zero_transition(), at_us, 1'b0);
		end
		// an early none edge: everything after it must be ignored
		if ($urandom_range(99) < 8) begin
			push_edge(EDGE_NONE, at_us + 16'(2 * h), 1'b0);
			push_edge(any_transition(), 16'($urandom), 1'b0);
		end
		push_edge(($urandom_range(99) < 75) ? EDGE_NONE : any_transition(), end_time(), 1'b1);
		if (pick < 30) begin
			idx = $urandom_range(frame_edges.size() - 2);
			w = frame_edges[idx];
			if ($urandom_range(1))
				w.edge_time = 16'($urandom);
			else
				w.edge_kind = 2'($urandom_range(3));
			frame_edges[idx] = w;
		end
	endfunction

	// Offer one edge word, hold it until accepted; valid stays up for a following word
	task automatic send_edge(input edge_word_t w);
		while (pace_gap(1'b1)) begin
			edge_valid <= 1'b0;
			@(posedge clk);
		end
		edge_valid <= 1'b1;
		edge_word <= w;
		@(posedge clk);
		while (!edge_ready)
			@(posedge clk);
		sb.note_edge(w);
		edges_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_edges.size(); i++)
			send_edge(frame_edges[i]);
		frames_sent++;
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic apply_settings(input cfg_t s);
		write_reg(REG_FORWARD_ACTION, 16'(s.forward_action));
		write_reg(REG_BACKWARD_ACTION, 16'(s.backward_action));
		write_reg(REG_MANGLED_ACTION, 16'(s.mangled_action));
		write_reg(REG_HALF_BIT_TIME, s.half_bit_time);
		write_reg(REG_BIT_TOLERANCE, s.bit_tolerance);
		write_reg(REG_FORWARD_DURATION, s.forward_duration);
		write_reg(REG_BACKWARD_DURATION, s.backward_duration);
		write_reg(REG_DURATION_TOLERANCE, s.duration_tolerance);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Drop valid, wait for every expected word, then let the pipeline run dry
	task automatic settle();
		edge_valid <= 1'b0;
		while (sb.pending_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	function automatic logic [1:0] pick_action();
		return ($urandom_range(99) < 60) ? 2'd3 : 2'($urandom_range(3));
	endfunction

	// Register setting per phase: defaults with mangled emit, all zero, all one,
	// decode-only and emit-only actions, then random actions and timing
	function automatic cfg_t pick_settings(int n);
		cfg_t s;
		int h;
		s.forward_action = RST_FORWARD_ACTION;
		s.backward_action = RST_BACKWARD_ACTION;
		s.mangled_action = RST_MANGLED_ACTION;
		s.half_bit_time = RST_HALF_BIT_TIME;
		s.bit_tolerance = RST_BIT_TOLERANCE;
		s.forward_duration = RST_FORWARD_DURATION;
		s.backward_duration = RST_BACKWARD_DURATION;
		s.duration_tolerance = RST_DURATION_TOLERANCE;
		case (n)
		1: s.mangled_action = 2'd3;
		2: s = '0;
		3: s = '1;
		4: begin
			s.forward_action = 2'd1;
			s.backward_action = 2'd2;
			s.mangled_action = 2'd2;
		end
		default: begin
			h = $urandom_range(60, 1200);
			s.forward_action = pick_action();
			s.backward_action = pick_action();
			s.mangled_action = pick_action();
			s.half_bit_time = 16'(h);
			s.bit_tolerance = 16'($urandom_range(1, h / 3 + 1));
			s.forward_duration = 16'($urandom_range(9000, 40000));
			s.backward_duration = 16'($urandom_range(2000, 9000));
			s.duration_tolerance = 16'($urandom_range(3000));
		end
		endcase
		return s;
	endfunction

	// Hand-picked frames at reset timing (half bit 417, tolerance 150)
	task automatic run_directed();
		// clean frame: odd first edge, bit 1, glitch, mid-bit edge, bit 0, forward end
		frame_edges.delete();
		push_edge(EDGE_ODD, 16'd0, 1'b0);
		push_edge(EDGE_RISING, 16'd417, 1'b0);
		push_edge(EDGE_RISING, 16'd1251, 1'b0);
		push_edge(EDGE_FALLING, 16'd1290, 1'b0);
		push_edge(EDGE_FALLING, 16'd1668, 1'b0);
		push_edge(EDGE_FALLING, 16'd2085, 1'b0);
		push_edge(EDGE_NONE, 16'd15411, 1'b1);
		send_frame();
		// none edge at the start check, backward end: reported as mangled
		frame_edges.delete();
		push_edge(EDGE_FALLING, 16'd100, 1'b0);
		push_edge(EDGE_NONE, 16'd417, 1'b0);
		push_edge(EDGE_RISING, 16'd8700, 1'b1);
		send_frame();
		// single-edge frame at the top of the time range
		frame_edges.delete();
		push_edge(EDGE_RISING, 16'hFFFF, 1'b1);
		send_frame();
		// gap between half and full bit: decode error
		frame_edges.delete();
		push_edge(EDGE_NONE, 16'd0, 1'b0);
		push_edge(EDGE_RISING, 16'd417, 1'b0);
		push_edge(EDGE_FALLING, 16'd1017, 1'b0);
		push_edge(EDGE_ODD, 16'd8000, 1'b1);
		send_frame();
		// falling start edge, duration just inside the forward window
		frame_edges.delete();
		push_edge(EDGE_RISING, 16'd5, 1'b0);
		push_edge(EDGE_FALLING, 16'd417, 1'b0);
		push_edge(EDGE_NONE, 16'd13912, 1'b1);
		send_frame();
		// start edge on the window edge, duration on the forward limit: no word
		frame_edges.delete();
		push_edge(EDGE_RISING, 16'd0, 1'b0);
		push_edge(EDGE_RISING, 16'd567, 1'b0);
		push_edge(EDGE_NONE, 16'd16911, 1'b1);
		send_frame();
	endtask

	// Frame channel: check accepted words, toggle ready by pacing
	initial begin
		forever begin
			@(posedge clk);
			if (frame_valid && frame_ready)
				sb.check_frame(frame_word);
			frame_ready <= !pace_gap(1'b0);
		end
	end

	// Watchdog: end the run when no word moves on either channel for too long
	always @(posedge clk) begin
		if ((edge_valid && edge_ready) || (frame_valid && frame_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles", QUIET_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		sb = new();
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		phase_count = 0;
		while ((edges_sent < TARGET_EDGES) && (phase_count < MAX_PHASES)) begin
			// phase zero keeps the reset values; later phases write registers while idle
			if (phase_count > 0) begin
				settle();
				if (phase_count == 1)
					write_reg(REG_SPARE, 16'($urandom));
				apply_settings(pick_settings(phase_count));
			end
			pace_mode = pace_t'(phase_count % 4);
			repeat (FRAMES_PER_PHASE) begin
				build_frame();
				send_frame();
			end
			phase_count++;
		end
		settle();
		$display("Sent %0d edge words in %0d frames over %0d register settings and %0d phases",
			edges_sent, frames_sent, settings_used + 1, phase_count);
		$display("Checked %0d frame words, %0d mismatches", sb.frames_checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ dali_edge_timing_decoder_unit.f @@
rtl/core/detd_pkg.sv
rtl/core/detd_front.sv
rtl/core/detd_queue.sv
rtl/core/detd_back.sv
rtl/core/dali_edge_timing_decoder_unit.sv
rtl/core/detd_checker.sv
verif/dali_edge_timing_decoder_unit_tb.sv
